/* sv/hsn_pkg.sv */
// Shared types and constants for the height field sampler.
// Used by the controller, the datapath and the arithmetic units.
`default_nettype none
package hsn_pkg;

  localparam int POS_W       = 18;
  localparam int DIVD_W      = 40;
  localparam int DIVS_W      = 25;
  localparam int QUOT_W      = 19;
  localparam int ROOT_IN_W   = 50;
  localparam int ROOT_W      = 25;
  localparam int DIFF_W      = 17;
  localparam int PROD_W      = 34;
  localparam int NSUM_W      = 37;
  localparam int SQ_W        = 34;
  localparam int ONE_Q12     = 4096;
  localparam int UNIT_Q14    = 16384;
  localparam int NORM_SHIFT  = 22;
  localparam int NUM_SAMPLES = 5;
  localparam int CELL_RESET  = 256;
  localparam int COUNT_RESET = 20;

  localparam logic       OP_LOAD  = 1'b0;
  localparam logic       OP_QUERY = 1'b1;
  localparam logic [1:0] REG_CELL_SIZE = 2'd0;
  localparam logic [1:0] REG_CELLS_X   = 2'd1;
  localparam logic [1:0] REG_CELLS_Z   = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_POS, S_PCHK, S_DIVX, S_DIVZ, S_RANGE,
    S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
    S_MUL1, S_MUL2, S_SUM, S_HSTART, S_DIVH, S_FIN, S_ZERO,
    S_SQ1, S_SQ2, S_SQ3, S_SSUM, S_SQS, S_SQRT, S_N0, S_N1, S_N2
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_POS, DP_CAPX, DP_CAPZ, DP_ADDR,
    DP_RD0, DP_RD1, DP_RD2, DP_RD3, DP_RD4,
    DP_MUL1, DP_MUL2, DP_SUM, DP_FIN, DP_ZERO,
    DP_DIFF, DP_SQX, DP_SQY, DP_SSUM, DP_NRMX, DP_NRMY, DP_NRMZ
  } dp_op_t;

  typedef enum logic [2:0] {
    DS_X, DS_Z, DS_H, DS_N0, DS_N1, DS_N2
  } div_sel_t;

  typedef struct packed {
    logic       accept;
    dp_op_t     op;
    logic       div_start;
    div_sel_t   div_sel;
    logic       sqrt_start;
    logic [2:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_bad;
    logic range_bad;
    logic div_done;
    logic sqrt_done;
  } dp_status_t;

endpackage
`default_nettype wire

/* sv/hsn_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on hsn_pkg for operand widths.
`default_nettype none
module hsn_div
  import hsn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   done,
  output logic [QUOT_W-1:0]      quot,
  output logic [DIVS_W-1:0]      rem
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DIVS_W-1:0] rem_r;
  logic [QUOT_W-1:0] quo_r;
  logic [DIVS_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [DIVS_W:0]   trial;
  logic              fits;

  always_comb begin
    trial = {rem_r, quo_r[QUOT_W-1]};
    fits  = trial >= {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(QUOT_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DIVS_W'(dividend[DIVD_W-1:QUOT_W]);
      quo_r <= dividend[QUOT_W-1:0];
      dvs_r <= divisor;
    end else if (run) begin
      if (fits) begin
        rem_r <= DIVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[DIVS_W-1:0];
      end
      quo_r <= {quo_r[QUOT_W-2:0], fits};
    end
  end

  assign quot = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

/* sv/hsn_sqrt.sv */
// Iterative integer square root, one result bit per cycle.
// Depends on hsn_pkg for operand widths.
`default_nettype none
module hsn_sqrt
  import hsn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [ROOT_IN_W-1:0] value,
  output logic                      done,
  output logic [ROOT_W-1:0]         root
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [ROOT_IN_W-1:0] v_r;
  logic [ROOT_IN_W-1:0] res_r;
  logic [ROOT_IN_W-1:0] bit_r;
  logic [ROOT_IN_W-1:0] trial;
  logic [CNT_W-1:0]     cnt;
  logic                 run;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(ROOT_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= value;
      res_r <= '0;
      bit_r <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
    end else if (run) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res_r[ROOT_W-1:0];

endmodule
`default_nettype wire

/* sv/hsn_datapath.sv */
// Datapath: config registers, node height memory, sample and normal arithmetic.
// Depends on hsn_pkg, hsn_div and hsn_sqrt.
`default_nettype none
module hsn_datapath
  import hsn_pkg::*;
#(
  parameter int MAX_CELLS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               operation,
  input  wire logic [5:0]         node_x,
  input  wire logic [5:0]         node_z,
  input  wire logic signed [15:0] node_height,
  input  wire logic signed [15:0] query_x,
  input  wire logic signed [15:0] query_z,
  output logic signed [15:0]      height,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z,
  output logic                    outside
);

  localparam int ROW   = MAX_CELLS + 1;
  localparam int DEPTH = ROW * ROW;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(ROW);

  logic [15:0] cell_size;
  logic [5:0]  cells_x;
  logic [5:0]  cells_z;

  logic signed [15:0] qx, qz;
  logic signed [POS_W-1:0] px, pz, off_x, off_z, cs_pos;
  logic [QUOT_W-1:0] ix, iz, cx, cz;
  logic [15:0] rx, rz;
  logic [AW-1:0] addr, rd_addr, wr_addr;
  logic wr_en;
  logic signed [15:0] height_table [DEPTH];
  logic signed [15:0] rd_data, na, nb, nc, nd, base;
  logic [15:0] w1, w2;
  logic signed [DIFF_W-1:0] e1, e2;
  logic signed [PROD_W-1:0] p1, p2;
  logic signed [PROD_W:0] psum;
  logic signed [NSUM_W-1:0] nsum;
  logic [NSUM_W-1:0] nmag;
  logic nneg;
  logic signed [QUOT_W:0] qs;
  logic signed [QUOT_W+1:0] h_full;
  logic signed [15:0] h_sat;
  logic signed [15:0] samp [NUM_SAMPLES];
  logic signed [DIFF_W-1:0] nx, ny;
  logic [SQ_W-1:0] sq_x, sq_y, ssum;
  logic [15:0] mag;
  logic [DIVD_W-1:0] div_a;
  logic [DIVS_W-1:0] div_b;
  logic div_done, sqrt_done;
  logic [QUOT_W-1:0] div_quot;
  logic [DIVS_W-1:0] div_rem;
  logic [ROOT_W-1:0] root;
  logic [15:0] nq;
  logic nrm_neg;
  logic signed [15:0] nrm_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= 16'(CELL_RESET);
      cells_x   <= 6'(COUNT_RESET);
      cells_z   <= 6'(COUNT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELL_SIZE: cell_size <= cfg_data;
        REG_CELLS_X:   cells_x   <= cfg_data[5:0];
        REG_CELLS_Z:   cells_z   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign cx = (QUOT_W'(cells_x) > QUOT_W'(MAX_CELLS)) ? QUOT_W'(MAX_CELLS) : QUOT_W'(cells_x);
  assign cz = (QUOT_W'(cells_z) > QUOT_W'(MAX_CELLS)) ? QUOT_W'(MAX_CELLS) : QUOT_W'(cells_z);

  assign wr_en = cmd.accept && (operation == OP_LOAD)
                 && (int'(node_x) <= MAX_CELLS) && (int'(node_z) <= MAX_CELLS);
  assign wr_addr = AW'(node_x) + AW'(node_z) * AW'(ROW);

  always_comb begin
    unique case (cmd.op)
      DP_RD1:  rd_addr = addr + AW'(1);
      DP_RD2:  rd_addr = addr + AW'(ROW);
      DP_RD3:  rd_addr = addr + AW'(ROW + 1);
      default: rd_addr = addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      height_table[wr_addr] <= node_height;
    end
    rd_data <= height_table[rd_addr];
  end

  assign cs_pos = $signed({2'b00, cell_size});

  always_comb begin
    off_x = '0;
    off_z = '0;
    unique case (cmd.k)
      3'd1:    off_x = cs_pos;
      3'd2:    off_x = -cs_pos;
      3'd3:    off_z = cs_pos;
      3'd4:    off_z = -cs_pos;
      default: ;
    endcase
  end

  assign status.pos_bad   = (cell_size == 16'd0) || px[POS_W-1] || pz[POS_W-1];
  assign status.range_bad = (ix >= cx) || (iz >= cz);
  assign status.div_done  = div_done;
  assign status.sqrt_done = sqrt_done;

  always_comb begin
    if (rx > rz) begin
      w1   = cell_size - rx;
      e1   = {na[15], na} - {nb[15], nb};
      w2   = rz;
      e2   = {nd[15], nd} - {nb[15], nb};
      base = nb;
    end else begin
      w1   = rx;
      e1   = {nd[15], nd} - {nc[15], nc};
      w2   = cell_size - rz;
      e2   = {na[15], na} - {nc[15], nc};
      base = nc;
    end
  end

  assign psum = {p1[PROD_W-1], p1} + {p2[PROD_W-1], p2};
  assign nsum = {psum[PROD_W], psum, 1'b0} + $signed({21'd0, cell_size});

  assign qs = nneg ? -$signed({1'b0, div_quot}) - $signed({{QUOT_W{1'b0}}, div_rem != '0})
                   : $signed({1'b0, div_quot});
  assign h_full = {{5{base[15]}}, base} + {qs[QUOT_W], qs};

  always_comb begin
    if (h_full > 21'sd32767) begin
      h_sat = 16'sd32767;
    end else if (h_full < -21'sd32768) begin
      h_sat = -16'sd32768;
    end else begin
      h_sat = h_full[15:0];
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DS_N0:   mag = nx[DIFF_W-1] ? 16'(-nx) : nx[15:0];
      DS_N1:   mag = ny[DIFF_W-1] ? 16'(-ny) : ny[15:0];
      default: mag = 16'(ONE_Q12);
    endcase
    unique case (cmd.div_sel)
      DS_X: begin
        div_a = DIVD_W'(px[POS_W-2:0]);
        div_b = DIVS_W'(cell_size);
      end
      DS_Z: begin
        div_a = DIVD_W'(pz[POS_W-2:0]);
        div_b = DIVS_W'(cell_size);
      end
      DS_H: begin
        div_a = DIVD_W'(nmag);
        div_b = DIVS_W'({cell_size, 1'b0});
      end
      default: begin
        div_a = (DIVD_W'(mag) << NORM_SHIFT) + DIVD_W'(root[ROOT_W-1:1]);
        div_b = DIVS_W'(root);
      end
    endcase
  end

  assign nq = (div_quot > QUOT_W'(UNIT_Q14)) ? 16'(UNIT_Q14) : div_quot[15:0];

  always_comb begin
    unique case (cmd.op)
      DP_NRMX: nrm_neg = nx[DIFF_W-1];
      DP_NRMY: nrm_neg = ny[DIFF_W-1];
      default: nrm_neg = 1'b0;
    endcase
  end

  assign nrm_val = nrm_neg ? -$signed(nq) : $signed(nq);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      qx <= query_x;
      qz <= query_z;
    end
    unique case (cmd.op)
      DP_POS: begin
        px <= {{2{qx[15]}}, qx} + off_x;
        pz <= {{2{qz[15]}}, qz} + off_z;
      end
      DP_CAPX: if (div_done) begin
        ix <= div_quot;
        rx <= div_rem[15:0];
      end
      DP_CAPZ: if (div_done) begin
        iz <= div_quot;
        rz <= div_rem[15:0];
      end
      DP_ADDR: addr <= AW'(ix[NW-1:0]) + AW'(iz[NW-1:0]) * AW'(ROW);
      DP_RD1:  na <= rd_data;
      DP_RD2:  nb <= rd_data;
      DP_RD3:  nc <= rd_data;
      DP_RD4:  nd <= rd_data;
      DP_MUL1: p1 <= $signed({1'b0, w1}) * e1;
      DP_MUL2: p2 <= $signed({1'b0, w2}) * e2;
      DP_SUM: begin
        nneg <= nsum[NSUM_W-1];
        nmag <= nsum[NSUM_W-1] ? NSUM_W'(-nsum) : NSUM_W'(nsum);
      end
      DP_FIN: begin
        samp[cmd.k] <= h_sat;
        if (cmd.k == 3'd0) begin
          outside <= 1'b0;
        end
      end
      DP_ZERO: begin
        samp[cmd.k] <= '0;
        if (cmd.k == 3'd0) begin
          outside <= 1'b1;
        end
      end
      DP_DIFF: begin
        nx <= {samp[2][15], samp[2]} - {samp[1][15], samp[1]};
        ny <= {samp[4][15], samp[4]} - {samp[3][15], samp[3]};
      end
      DP_SQX:  sq_x <= $unsigned(SQ_W'(nx) * SQ_W'(nx));
      DP_SQY:  sq_y <= $unsigned(SQ_W'(ny) * SQ_W'(ny));
      DP_SSUM: ssum <= sq_x + sq_y + SQ_W'(ONE_Q12 * ONE_Q12);
      DP_NRMX: if (div_done) normal_x <= nrm_val;
      DP_NRMY: if (div_done) normal_y <= nrm_val;
      DP_NRMZ: if (div_done) normal_z <= nrm_val;
      default: ;
    endcase
  end

  assign height = samp[0];

  hsn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  hsn_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .value ({ssum, 16'd0}),
    .done  (sqrt_done),
    .root  (root)
  );

endmodule
`default_nettype wire

/* sv/hsn_ctrl.sv */
// Controller state machine sequencing samples, square root and normal divisions.
// Depends on hsn_pkg for state, command and status types.
`default_nettype none
module hsn_ctrl
  import hsn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       operation,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy,
  output logic            done
);

  state_t     state, state_next;
  logic [2:0] k, k_next;
  logic       done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      k     <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    k_next         = k;
    done_next      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.op         = DP_NOP;
    cmd.div_start  = 1'b0;
    cmd.div_sel    = DS_X;
    cmd.sqrt_start = 1'b0;
    cmd.k          = k;
    unique case (state)
      S_IDLE: begin
        cmd.accept = start;
        if (start && operation == OP_QUERY) begin
          k_next     = '0;
          state_next = S_POS;
        end
      end
      S_POS: begin
        cmd.op     = DP_POS;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        if (status.pos_bad) begin
          state_next = S_ZERO;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIVX;
        end
      end
      S_DIVX: begin
        cmd.op = DP_CAPX;
        if (status.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_Z;
          state_next    = S_DIVZ;
        end
      end
      S_DIVZ: begin
        cmd.op = DP_CAPZ;
        if (status.div_done) begin
          state_next = S_RANGE;
        end
      end
      S_RANGE: begin
        if (status.range_bad) begin
          state_next = S_ZERO;
        end else begin
          cmd.op     = DP_ADDR;
          state_next = S_RD0;
        end
      end
      S_RD0: begin
        cmd.op     = DP_RD0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.op     = DP_RD1;
        state_next = S_RD2;
      end
      S_RD2: begin
        cmd.op     = DP_RD2;
        state_next = S_RD3;
      end
      S_RD3: begin
        cmd.op     = DP_RD3;
        state_next = S_RD4;
      end
      S_RD4: begin
        cmd.op     = DP_RD4;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.op     = DP_MUL1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.op     = DP_MUL2;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = DP_SUM;
        state_next = S_HSTART;
      end
      S_HSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_H;
        state_next    = S_DIVH;
      end
      S_DIVH: begin
        if (status.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN, S_ZERO: begin
        cmd.op = (state == S_FIN) ? DP_FIN : DP_ZERO;
        if (k == 3'(NUM_SAMPLES - 1)) begin
          state_next = S_SQ1;
        end else begin
          k_next     = k + 3'd1;
          state_next = S_POS;
        end
      end
      S_SQ1: begin
        cmd.op     = DP_DIFF;
        state_next = S_SQ2;
      end
      S_SQ2: begin
        cmd.op     = DP_SQX;
        state_next = S_SQ3;
      end
      S_SQ3: begin
        cmd.op     = DP_SQY;
        state_next = S_SSUM;
      end
      S_SSUM: begin
        cmd.op     = DP_SSUM;
        state_next = S_SQS;
      end
      S_SQS: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT;
      end
      S_SQRT: begin
        if (status.sqrt_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_N0;
          state_next    = S_N0;
        end
      end
      S_N0: begin
        cmd.op = DP_NRMX;
        if (status.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_N1;
          state_next    = S_N1;
        end
      end
      S_N1: begin
        cmd.op      = DP_NRMY;
        cmd.div_sel = DS_N1;
        if (status.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DS_N2;
          state_next    = S_N2;
        end
      end
      S_N2: begin
        cmd.op = DP_NRMZ;
        if (status.div_done) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/heightfield_sample_and_normal.sv */
// Height field sampler: a load word writes one node if both indices are within
// MAX_CELLS; busy stays low. A query word takes five samples, each with up to two
// 19-step divisions for the cell, four memory reads and one 19-step rounding
// division, then a 25-step square root and three 19-step normal divisions
// before its done strobe. One word in flight; done is a one-cycle strobe.
// Synchronous reset returns to idle and restores the register defaults.
`default_nettype none
module heightfield_sample_and_normal
  import hsn_pkg::*;
#(
  parameter int MAX_CELLS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               operation,
  input  wire logic [5:0]         node_x,
  input  wire logic [5:0]         node_z,
  input  wire logic signed [15:0] node_height,
  input  wire logic signed [15:0] query_x,
  input  wire logic signed [15:0] query_z,
  output logic                    done,
  output logic signed [15:0]      height,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z,
  output logic                    outside,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = !busy;

  hsn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  hsn_datapath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .node_x      (node_x),
    .node_z      (node_z),
    .node_height (node_height),
    .query_x     (query_x),
    .query_z     (query_z),
    .height      (height),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .outside     (outside)
  );

endmodule
`default_nettype wire

/* sv/hsn_checker.sv */
// Port-level checks for the height field sampler, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none
module hsn_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        operation,
  input wire logic        done,
  input wire logic [15:0] height,
  input wire logic        outside
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation) |=> busy)
    else $error("query word did not raise busy");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !operation) |=> !busy)
    else $error("load word raised busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (done && outside) |-> (height == 16'd0))
    else $error("outside result with nonzero height");

endmodule

bind heightfield_sample_and_normal hsn_checker u_hsn_checker (.*);
`default_nettype wire

/* bench/heightfield_sample_and_normal_tb.sv */
// Self-checking bench for heightfield_sample_and_normal: node loads, queries and
// register writes, with a built-in predictor of the interpolated height and normal.
// Depends on hsn_pkg and the heightfield_sample_and_normal RTL.
`default_nettype none
module heightfield_sample_and_normal_tb
  import hsn_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW = 33;
  localparam int NODES = ROW * ROW;

  typedef struct {
    logic signed [15:0] height;
    logic signed [15:0] nrm_x;
    logic signed [15:0] nrm_y;
    logic signed [15:0] nrm_z;
    logic               outside;
  } sample_t;

  class height_sampler;
    longint             cell_len;
    int                 cnt_x;
    int                 cnt_z;
    logic signed [15:0] heights[NODES];
    sample_t            pending_samples[$];
    int                 errors;

    function new();
      cell_len = CELL_RESET;
      cnt_x = COUNT_RESET;
      cnt_z = COUNT_RESET;
      errors = 0;
      foreach (heights[i]) heights[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_CELL_SIZE: cell_len = data;
        REG_CELLS_X: cnt_x = data[5:0];
        REG_CELLS_Z: cnt_z = data[5:0];
        default: ;
      endcase
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint interp(longint px, longint pz, output bit out);
      longint cx, cz, ix, iz, rx, rz, a, b, c, d, num, base, h;
      cx = (cnt_x > 32) ? 32 : cnt_x;
      cz = (cnt_z > 32) ? 32 : cnt_z;
      out = 1;
      if (cell_len == 0) return 0;
      ix = floor_div(px, cell_len);
      iz = floor_div(pz, cell_len);
      if (ix < 0 || ix >= cx || iz < 0 || iz >= cz) return 0;
      out = 0;
      rx = px - ix * cell_len;
      rz = pz - iz * cell_len;
      a = heights[ix + iz * ROW];
      b = heights[ix + 1 + iz * ROW];
      c = heights[ix + (iz + 1) * ROW];
      d = heights[ix + 1 + (iz + 1) * ROW];
      if (rx > rz) begin
        num = (cell_len - rx) * (a - b) + rz * (d - b);
        base = b;
      end else begin
        num = rx * (d - c) + (cell_len - rz) * (a - c);
        base = c;
      end
      h = base + floor_div(2 * num + cell_len, 2 * cell_len);
      if (h > 32767) h = 32767;
      if (h < -32768) h = -32768;
      return h;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint unit_comp(longint v, longint unsigned len);
      longint unsigned mag, q;
      mag = (v < 0) ? -v : v;
      q = ((mag << 22) + len / 2) / len;
      if (q > UNIT_Q14) q = UNIT_Q14;
      return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void note_word(logic op, logic [5:0] nx, logic [5:0] nz, logic signed [15:0] nh,
                            logic signed [15:0] qx, logic signed [15:0] qz);
      sample_t        e;
      bit             out, dummy;
      longint         x, z, h0, h1, h2, h3, dx, dz;
      longint unsigned s, len;
      if (op == OP_LOAD) begin
        if (nx <= 32 && nz <= 32) heights[nx + nz * ROW] = nh;
        return;
      end
      x = qx;
      z = qz;
      e.height = 16'(interp(x, z, out));
      h0 = interp(x + cell_len, z, dummy);
      h1 = interp(x - cell_len, z, dummy);
      h2 = interp(x, z + cell_len, dummy);
      h3 = interp(x, z - cell_len, dummy);
      dx = h1 - h0;
      dz = h3 - h2;
      s = dx * dx + dz * dz + ONE_Q12 * ONE_Q12;
      len = int_sqrt(s << 16);
      e.nrm_x = 16'(unit_comp(dx, len));
      e.nrm_y = 16'(unit_comp(dz, len));
      e.nrm_z = 16'(unit_comp(ONE_Q12, len));
      e.outside = out;
      pending_samples.push_back(e);
    endfunction

    function void check_result(sample_t got);
      sample_t e;
      if (pending_samples.size() == 0) begin
        $error("unexpected result height=%0d", got.height);
        errors++;
        return;
      end
      e = pending_samples.pop_front();
      if (got.height !== e.height) begin
        $error("height exp %0d got %0d", e.height, got.height); errors++;
      end
      if (got.nrm_x !== e.nrm_x) begin
        $error("normal_x exp %0d got %0d", e.nrm_x, got.nrm_x); errors++;
      end
      if (got.nrm_y !== e.nrm_y) begin
        $error("normal_y exp %0d got %0d", e.nrm_y, got.nrm_y); errors++;
      end
      if (got.nrm_z !== e.nrm_z) begin
        $error("normal_z exp %0d got %0d", e.nrm_z, got.nrm_z); errors++;
      end
      if (got.outside !== e.outside) begin
        $error("outside exp %0d got %0d", e.outside, got.outside); errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic               operation = OP_LOAD;
  logic [5:0]         node_x = '0;
  logic [5:0]         node_z = '0;
  logic signed [15:0] node_height = '0;
  logic signed [15:0] query_x = '0;
  logic signed [15:0] query_z = '0;
  logic               done;
  logic signed [15:0] height;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               outside;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  height_sampler sampler = new();
  bit            quiet = 0;

  heightfield_sample_and_normal u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .node_x(node_x), .node_z(node_z), .node_height(node_height),
    .query_x(query_x), .query_z(query_z), .done(done), .height(height),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .outside(outside), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    sample_t got;
    if (!rst && done) begin
      got.height = height;
      got.nrm_x = normal_x;
      got.nrm_y = normal_y;
      got.nrm_z = normal_z;
      got.outside = outside;
      sampler.check_result(got);
    end
  end

  initial begin
    #100ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_word(logic op, logic [5:0] nx, logic [5:0] nz, logic signed [15:0] nh,
                           logic signed [15:0] qx, logic signed [15:0] qz);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    node_x <= nx;
    node_z <= nz;
    node_height <= nh;
    query_x <= qx;
    query_z <= qz;
    do @(posedge clk); while (busy);
    sampler.note_word(op, nx, nz, nh, qx, qz);
  endtask

  task automatic load_node(int nx, int nz, int nh);
    send_word(OP_LOAD, 6'(nx), 6'(nz), 16'(nh), 16'($urandom), 16'($urandom));
  endtask

  task automatic query_at(int qx, int qz);
    send_word(OP_QUERY, 6'($urandom), 6'($urandom), 16'($urandom), 16'(qx), 16'(qz));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sampler.pending_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    if ($urandom_range(0, 1)) begin
      cfg_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sampler.write_reg(idx, data);
  endtask

  task automatic set_grid(int cs, int cx, int cz);
    drain();
    write_reg(REG_CELL_SIZE, 16'(cs));
    write_reg(REG_CELLS_X, 16'(cx));
    write_reg(REG_CELLS_Z, 16'(cz));
    cfg_valid <= 1'b0;
  endtask

  function automatic int clip16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int rand_height();
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(0, 255) - 128;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic random_words(int n);
    longint span, x, z;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 9) == 0)
          load_node($urandom_range(0, 63), $urandom_range(0, 63), rand_height());
        else
          load_node($urandom_range(0, 32), $urandom_range(0, 32), rand_height());
      end else begin
        span = sampler.cell_len * (((sampler.cnt_x > sampler.cnt_z) ? sampler.cnt_x
                                                                    : sampler.cnt_z) + 2);
        if (span > 65535) span = 65535;
        x = longint'($urandom_range(0, span)) - sampler.cell_len;
        z = longint'($urandom_range(0, span)) - sampler.cell_len;
        case ($urandom_range(0, 9))
          0, 1: query_at($urandom, $urandom);
          2: query_at(clip16(x), clip16(x));
          default: query_at(clip16(x), clip16(z));
        endcase
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int j = 0; j < ROW; j++)
      for (int i = 0; i < ROW; i++)
        load_node(i, j, rand_height());
    set_grid(256, 20, 20);
    load_node(0, 0, 32767);
    load_node(1, 0, -32768);
    load_node(0, 1, -32768);
    load_node(1, 1, 32767);
    load_node(40, 3, 100);
    load_node(3, 33, 100);
    load_node(63, 63, -1);
    query_at(0, 0);
    query_at(128, 128);
    query_at(200, 100);
    query_at(100, 200);
    query_at(-1, 0);
    query_at(0, -1);
    query_at(5119, 5119);
    query_at(5120, 0);
    query_at(0, 5120);
    query_at(32767, 32767);
    query_at(-32768, -32768);
    query_at(255, 1);
    random_words(60);
    set_grid(1, 32, 32);
    query_at(31, 31);
    query_at(32, 0);
    random_words(60);
    set_grid(65535, 1, 1);
    query_at(32767, 32767);
    query_at(32767, 0);
    random_words(60);
    set_grid(0, 5, 5);
    query_at(0, 0);
    random_words(30);
    set_grid(37, 0, 63);
    random_words(60);
    set_grid(700, 63, 7);
    random_words(60);
    set_grid(1024, 32, 32);
    random_words(80);
    for (int p = 0; p < 4; p++) begin
      set_grid($urandom_range(16, 2000), $urandom_range(1, 32), $urandom_range(1, 32));
      random_words(80);
    end
    quiet = 1;
    random_words(60);
    drain();
    repeat (500) @(posedge clk);
    if (sampler.errors == 0 && sampler.pending_samples.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
